>>> design/i2cm_pkg.sv
// Package of the I2C master bit engine: types, codes and reset values.
// Used by the channel interfaces, the engine and the top level; depends on nothing.
package i2cm_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BIT_CNT_W = 3;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_W - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [BYTE_W-1:0] DELAY_RST       = 8'd15;
  localparam logic [BYTE_W-1:0] SHORT_DELAY_RST = 8'd6;
  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [2:0] {
    FN_START    = 3'd0,
    FN_STOP     = 3'd1,
    FN_WRITE    = 3'd2,
    FN_READ     = 3'd3,
    FN_WAIT_ACK = 3'd4,
    FN_ACK_BIT  = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WA_A,
    PH_WA_B,
    PH_WA_POLL,
    PH_WR_D,
    PH_WR_H,
    PH_WR_L,
    PH_RD_L,
    PH_RD_H,
    PH_AK_L,
    PH_AK_H
  } phase_e;

  typedef struct packed {
    logic              cmd_valid;
    logic [2:0]        func;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_flag;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic              scl_release;
    logic              sda_release;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_error;
  } res_t;

endpackage

>>> design/i2cm_in_if.sv
// Tick channel into the I2C master bit engine: valid, ready and the tick fields.
// Depends on i2cm_pkg for the byte width.
interface i2cm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd_valid;
  logic [2:0]                func;
  logic [i2cm_pkg::BYTE_W-1:0] tx_byte;
  logic                      ack_flag;
  logic                      sda_in;

  modport source (output valid, cmd_valid, func, tx_byte, ack_flag, sda_in, input ready);
  modport sink   (input valid, cmd_valid, func, tx_byte, ack_flag, sda_in, output ready);
endinterface

>>> design/i2cm_out_if.sv
// Result channel out of the I2C master bit engine: valid, ready and the line levels.
// Depends on i2cm_pkg for the byte width.
interface i2cm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      scl_release;
  logic                      sda_release;
  logic                      busy_res;
  logic                      done_res;
  logic [i2cm_pkg::BYTE_W-1:0] rx_byte;
  logic                      ack_error;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  ack_error, input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  ack_error, output ready);
endinterface

>>> design/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: tick input register, engine and result register.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if and i2cm_engine.
//
//  Channel  Dir  Handshake     Contents
//  cmd_i    in   valid/ready   cmd_valid, func, tx_byte, ack_flag, sda_in (one tick)
//  res_o    out  valid/ready   scl_release, sda_release, busy_res, done_res, rx_byte, ack_error
//  cfg      in   cfg_we_i      cfg_idx_i selects delay, short delay or ack timeout
//
// One tick is accepted per clock cycle while cmd_i.ready is high; the tick waits in the input register
// and the engine steps on it at the same edge that loads the result register with its result.
// The engine steps once per tick, when the result register is empty or being taken.
// A stalled result holds the engine and, once the input register is full, cmd_i.ready.
// Reset puts the bus lines released, the engine idle and the registers to their defaults.
module i2c_master_bit_engine_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [i2cm_pkg::BYTE_W-1:0]    cfg_data_i,
  i2cm_in_if.sink                        cmd_i,
  i2cm_out_if.source                     res_o
);

  logic           in_valid_q, out_valid_q, step;
  i2cm_pkg::cmd_t in_q;
  i2cm_pkg::res_t out_q, eng_res;

  assign step        = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || step;

  i2cm_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .cmd_i      (in_q),
    .res_o      (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.valid && cmd_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q.cmd_valid <= cmd_i.cmd_valid;
      in_q.func      <= cmd_i.func;
      in_q.tx_byte   <= cmd_i.tx_byte;
      in_q.ack_flag  <= cmd_i.ack_flag;
      in_q.sda_in    <= cmd_i.sda_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= eng_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.scl_release = out_q.scl_release;
  assign res_o.sda_release = out_q.sda_release;
  assign res_o.busy_res    = out_q.busy_res;
  assign res_o.done_res    = out_q.done_res;
  assign res_o.rx_byte     = out_q.rx_byte;
  assign res_o.ack_error   = out_q.ack_error;

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("engine step lost its result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("result shows done while busy");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_q))
    else $error("waiting tick dropped or overwritten");

endmodule

>>> design/i2cm_engine.sv
// Bus engine state machine, configuration registers and the per-tick update.
// Depends on i2cm_pkg; the result is combinational from the state and the current tick.
module i2cm_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [i2cm_pkg::BYTE_W-1:0]      cfg_data_i,
  input  logic                             step_i,
  input  i2cm_pkg::cmd_t                   cmd_i,
  output i2cm_pkg::res_t                   res_o
);

  i2cm_pkg::phase_e phase_q, phase_d;
  logic [i2cm_pkg::BYTE_W-1:0]    delay_q, short_q, timeout_q;
  logic [i2cm_pkg::BIT_CNT_W-1:0] bit_q, bit_d;
  logic [i2cm_pkg::BYTE_W-1:0]    shift_q, shift_d;
  logic [i2cm_pkg::BYTE_W-1:0]    dly_q, dly_d;
  logic [i2cm_pkg::BYTE_W-1:0]    poll_q, poll_d;
  logic [i2cm_pkg::BYTE_W-1:0]    rx_q, rx_d;
  logic scl_q, scl_d, sda_q, sda_d, ack_q, ack_d, err_q, err_d;
  logic expired, timed_out, last_bit, done;

  function automatic logic [i2cm_pkg::BYTE_W-1:0] load_fn(
    input logic [i2cm_pkg::BYTE_W-1:0] d
  );
    // A zero setting behaves as a one-tick delay.
    return (d == '0) ? i2cm_pkg::BYTE_W'(1) : d;
  endfunction

  assign expired   = (dly_q <= i2cm_pkg::BYTE_W'(1));
  assign timed_out = (poll_q >= timeout_q);
  assign last_bit  = (bit_q == i2cm_pkg::LAST_BIT);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      i2cm_pkg::PH_IDLE: begin
        if (cmd_i.cmd_valid) begin
          case (cmd_i.func)
            i2cm_pkg::FN_START:    phase_d = i2cm_pkg::PH_ST_A;
            i2cm_pkg::FN_STOP:     phase_d = i2cm_pkg::PH_SP_A;
            i2cm_pkg::FN_WRITE:    phase_d = i2cm_pkg::PH_WR_D;
            i2cm_pkg::FN_READ:     phase_d = i2cm_pkg::PH_RD_L;
            i2cm_pkg::FN_WAIT_ACK: phase_d = i2cm_pkg::PH_WA_A;
            i2cm_pkg::FN_ACK_BIT:  phase_d = i2cm_pkg::PH_AK_L;
            default:               phase_d = i2cm_pkg::PH_IDLE;
          endcase
        end
      end
      i2cm_pkg::PH_ST_A: if (expired) phase_d = i2cm_pkg::PH_ST_B;
      i2cm_pkg::PH_ST_B: if (expired) phase_d = i2cm_pkg::PH_IDLE;
      i2cm_pkg::PH_SP_A: if (expired) phase_d = i2cm_pkg::PH_SP_B;
      i2cm_pkg::PH_SP_B: if (expired) phase_d = i2cm_pkg::PH_IDLE;
      i2cm_pkg::PH_WA_A: if (expired) phase_d = i2cm_pkg::PH_WA_B;
      i2cm_pkg::PH_WA_B: if (expired) phase_d = i2cm_pkg::PH_WA_POLL;
      i2cm_pkg::PH_WA_POLL: begin
        if (!cmd_i.sda_in)  phase_d = i2cm_pkg::PH_IDLE;
        else if (timed_out) phase_d = i2cm_pkg::PH_SP_A;
      end
      i2cm_pkg::PH_WR_D: if (expired) phase_d = i2cm_pkg::PH_WR_H;
      i2cm_pkg::PH_WR_H: if (expired) phase_d = i2cm_pkg::PH_WR_L;
      i2cm_pkg::PH_WR_L: begin
        if (expired) phase_d = last_bit ? i2cm_pkg::PH_IDLE : i2cm_pkg::PH_WR_D;
      end
      i2cm_pkg::PH_RD_L: if (expired) phase_d = i2cm_pkg::PH_RD_H;
      i2cm_pkg::PH_RD_H: begin
        if (expired) phase_d = last_bit ? i2cm_pkg::PH_AK_L : i2cm_pkg::PH_RD_L;
      end
      i2cm_pkg::PH_AK_L: if (expired) phase_d = i2cm_pkg::PH_AK_H;
      i2cm_pkg::PH_AK_H: if (expired) phase_d = i2cm_pkg::PH_IDLE;
      default:           phase_d = i2cm_pkg::PH_IDLE;
    endcase
  end

  // Lines, counters and data path.
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    err_d   = err_q;
    done    = 1'b0;
    // Every phase but idle and the poll counts its delay down.
    if (phase_q != i2cm_pkg::PH_IDLE && phase_q != i2cm_pkg::PH_WA_POLL && !expired) begin
      dly_d = dly_q - i2cm_pkg::BYTE_W'(1);
    end else begin
      dly_d = dly_q;
    end
    unique case (phase_q)
      i2cm_pkg::PH_IDLE: begin
        if (cmd_i.cmd_valid) begin
          case (cmd_i.func)
            i2cm_pkg::FN_START: begin
              scl_d = 1'b1;
              sda_d = 1'b1;
              dly_d = load_fn(delay_q);
            end
            i2cm_pkg::FN_STOP: begin
              scl_d = 1'b0;
              sda_d = 1'b0;
              dly_d = load_fn(delay_q);
            end
            i2cm_pkg::FN_WRITE: begin
              shift_d = cmd_i.tx_byte;
              bit_d   = '0;
              scl_d   = 1'b0;
              sda_d   = cmd_i.tx_byte[i2cm_pkg::BYTE_W-1];
              dly_d   = load_fn(delay_q);
            end
            i2cm_pkg::FN_READ: begin
              shift_d = '0;
              bit_d   = '0;
              ack_d   = cmd_i.ack_flag;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              dly_d   = load_fn(delay_q);
            end
            i2cm_pkg::FN_WAIT_ACK: begin
              poll_d = '0;
              sda_d  = 1'b1;
              dly_d  = load_fn(short_q);
            end
            i2cm_pkg::FN_ACK_BIT: begin
              ack_d = cmd_i.ack_flag;
              scl_d = 1'b0;
              sda_d = !cmd_i.ack_flag;
              dly_d = load_fn(delay_q);
            end
            default: ;
          endcase
        end
      end
      i2cm_pkg::PH_ST_A: begin
        if (expired) begin
          sda_d = 1'b0;
          dly_d = load_fn(delay_q);
        end
      end
      i2cm_pkg::PH_ST_B: begin
        if (expired) begin
          scl_d = 1'b0;
          done  = 1'b1;
        end
      end
      i2cm_pkg::PH_SP_A: begin
        if (expired) begin
          scl_d = 1'b1;
          sda_d = 1'b1;
          dly_d = load_fn(delay_q);
        end
      end
      i2cm_pkg::PH_SP_B: done = expired;
      i2cm_pkg::PH_WA_A: begin
        if (expired) begin
          scl_d = 1'b1;
          dly_d = load_fn(short_q);
        end
      end
      i2cm_pkg::PH_WA_B: ;
      i2cm_pkg::PH_WA_POLL: begin
        if (!cmd_i.sda_in) begin
          scl_d = 1'b0;
          err_d = 1'b0;
          done  = 1'b1;
        end else if (timed_out) begin
          // Give up: flag the error and release the bus with a stop condition.
          err_d = 1'b1;
          scl_d = 1'b0;
          sda_d = 1'b0;
          dly_d = load_fn(delay_q);
        end else begin
          poll_d = poll_q + i2cm_pkg::BYTE_W'(1);
        end
      end
      i2cm_pkg::PH_WR_D: begin
        if (expired) begin
          scl_d = 1'b1;
          dly_d = load_fn(delay_q);
        end
      end
      i2cm_pkg::PH_WR_H: begin
        if (expired) begin
          scl_d = 1'b0;
          dly_d = load_fn(delay_q);
        end
      end
      i2cm_pkg::PH_WR_L: begin
        if (expired) begin
          if (last_bit) begin
            done = 1'b1;
          end else begin
            bit_d   = bit_q + i2cm_pkg::BIT_CNT_W'(1);
            shift_d = {shift_q[i2cm_pkg::BYTE_W-2:0], 1'b0};
            sda_d   = shift_q[i2cm_pkg::BYTE_W-2];
            dly_d   = load_fn(delay_q);
          end
        end
      end
      i2cm_pkg::PH_RD_L: begin
        if (expired) begin
          scl_d   = 1'b1;
          shift_d = {shift_q[i2cm_pkg::BYTE_W-2:0], cmd_i.sda_in};
          dly_d   = load_fn(short_q);
        end
      end
      i2cm_pkg::PH_RD_H: begin
        if (expired) begin
          scl_d = 1'b0;
          dly_d = load_fn(delay_q);
          if (last_bit) begin
            rx_d  = shift_q;
            sda_d = !ack_q;
          end else begin
            bit_d = bit_q + i2cm_pkg::BIT_CNT_W'(1);
          end
        end
      end
      i2cm_pkg::PH_AK_L: begin
        if (expired) begin
          scl_d = 1'b1;
          dly_d = load_fn(delay_q);
        end
      end
      i2cm_pkg::PH_AK_H: begin
        if (expired) begin
          scl_d = 1'b0;
          done  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.scl_release = scl_d;
    res_o.sda_release = sda_d;
    res_o.busy_res    = (phase_d != i2cm_pkg::PH_IDLE);
    res_o.done_res    = done;
    res_o.rx_byte     = rx_d;
    res_o.ack_error   = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= i2cm_pkg::DELAY_RST;
      short_q   <= i2cm_pkg::SHORT_DELAY_RST;
      timeout_q <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cm_pkg::CFG_DELAY:       delay_q   <= cfg_data_i;
        i2cm_pkg::CFG_SHORT_DELAY: short_q   <= cfg_data_i;
        i2cm_pkg::CFG_ACK_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cm_pkg::PH_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      dly_q   <= '0;
      poll_q  <= '0;
      rx_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      dly_q   <= dly_d;
      poll_q  <= poll_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      err_q   <= err_d;
    end
  end

  // A finished command always leaves the engine idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> phase_q == i2cm_pkg::PH_IDLE)
    else $error("done without return to idle");

  // A high poll at the timeout gives up with the error flag set and starts a stop.
  a_poll_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == i2cm_pkg::PH_WA_POLL && cmd_i.sda_in && timed_out
    |=> phase_q == i2cm_pkg::PH_SP_A && err_q)
    else $error("ack timeout did not start a stop");

  // Both lines are released while the stop condition is held.
  a_stop_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == i2cm_pkg::PH_SP_B |-> scl_q && sda_q)
    else $error("stop hold phase with a line driven low");

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the I2C master bit engine: drives one bus tick per
// transaction and checks every result against a predictor of the engine.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if and i2c_master_bit_engine_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_data_i;

  i2cm_in_if  cmd_if ();
  i2cm_out_if res_if ();

  i2c_master_bit_engine_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  // Predicted engine state and its copy of the configuration registers.
  phase_e      eng_phase;
  logic [3:0]  bit_idx;
  logic [7:0]  shreg;
  logic [7:0]  dly_cnt;
  logic [7:0]  poll_cnt;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_lvl;
  logic [7:0]  rx_last;
  logic        err_lvl;
  logic [7:0]  cfg_delay;
  logic [7:0]  cfg_short;
  logic [7:0]  cfg_timeout;

  cmd_t        bus_ticks_q[$];
  res_t        expected_lines_q[$];
  cmd_t        offered;
  res_t        predicted;
  res_t        want;
  int unsigned mismatches;
  int unsigned commands_issued;
  int unsigned ticks_pushed;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pat;
  logic [3:0]  stall_pos;
  int unsigned stall_age;

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] nonzero(input logic [7:0] d);
    return (d == 8'd0) ? 8'd1 : d;
  endfunction

  function automatic bit delay_over();
    if (dly_cnt > 8'd1) begin
      dly_cnt--;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic engine_reset();
    eng_phase   = PH_IDLE;
    bit_idx     = '0;
    shreg       = '0;
    dly_cnt     = '0;
    poll_cnt    = '0;
    scl_lvl     = 1'b1;
    sda_lvl     = 1'b1;
    ack_lvl     = 1'b0;
    rx_last     = '0;
    err_lvl     = 1'b0;
    cfg_delay   = DELAY_RST;
    cfg_short   = SHORT_DELAY_RST;
    cfg_timeout = ACK_TIMEOUT_RST;
  endtask

  // One bus tick of the engine; the result shows the levels after the tick.
  task automatic engine_step(input cmd_t t, output res_t r);
    logic done;
    done = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        if (t.cmd_valid) begin
          case (t.func)
            FN_START: begin
              scl_lvl = 1'b1; sda_lvl = 1'b1; dly_cnt = nonzero(cfg_delay); eng_phase = PH_ST_A;
            end
            FN_STOP: begin
              scl_lvl = 1'b0; sda_lvl = 1'b0; dly_cnt = nonzero(cfg_delay); eng_phase = PH_SP_A;
            end
            FN_WRITE: begin
              shreg = t.tx_byte; bit_idx = '0; scl_lvl = 1'b0; sda_lvl = t.tx_byte[7];
              dly_cnt = nonzero(cfg_delay); eng_phase = PH_WR_D;
            end
            FN_READ: begin
              shreg = '0; bit_idx = '0; ack_lvl = t.ack_flag; scl_lvl = 1'b0; sda_lvl = 1'b1;
              dly_cnt = nonzero(cfg_delay); eng_phase = PH_RD_L;
            end
            FN_WAIT_ACK: begin
              poll_cnt = '0; sda_lvl = 1'b1; dly_cnt = nonzero(cfg_short); eng_phase = PH_WA_A;
            end
            FN_ACK_BIT: begin
              ack_lvl = t.ack_flag; scl_lvl = 1'b0; sda_lvl = ~t.ack_flag;
              dly_cnt = nonzero(cfg_delay); eng_phase = PH_AK_L;
            end
            default: ;
          endcase
        end
      end
      PH_ST_A: if (delay_over()) begin
        sda_lvl = 1'b0; dly_cnt = nonzero(cfg_delay); eng_phase = PH_ST_B;
      end
      PH_ST_B: if (delay_over()) begin
        scl_lvl = 1'b0; eng_phase = PH_IDLE; done = 1'b1;
      end
      PH_SP_A: if (delay_over()) begin
        scl_lvl = 1'b1; sda_lvl = 1'b1; dly_cnt = nonzero(cfg_delay); eng_phase = PH_SP_B;
      end
      PH_SP_B: if (delay_over()) begin
        eng_phase = PH_IDLE; done = 1'b1;
      end
      PH_WA_A: if (delay_over()) begin
        scl_lvl = 1'b1; dly_cnt = nonzero(cfg_short); eng_phase = PH_WA_B;
      end
      PH_WA_B: if (delay_over()) eng_phase = PH_WA_POLL;
      PH_WA_POLL: begin
        if (!t.sda_in) begin
          scl_lvl = 1'b0; err_lvl = 1'b0; eng_phase = PH_IDLE; done = 1'b1;
        end else if (poll_cnt >= cfg_timeout) begin
          // The slave never answered: flag it and release the bus with a stop.
          err_lvl = 1'b1; scl_lvl = 1'b0; sda_lvl = 1'b0;
          dly_cnt = nonzero(cfg_delay); eng_phase = PH_SP_A;
        end else begin
          poll_cnt++;
        end
      end
      PH_WR_D: if (delay_over()) begin
        scl_lvl = 1'b1; dly_cnt = nonzero(cfg_delay); eng_phase = PH_WR_H;
      end
      PH_WR_H: if (delay_over()) begin
        scl_lvl = 1'b0; dly_cnt = nonzero(cfg_delay); eng_phase = PH_WR_L;
      end
      PH_WR_L: if (delay_over()) begin
        if (bit_idx >= 4'd7) begin
          eng_phase = PH_IDLE; done = 1'b1;
        end else begin
          bit_idx++;
          shreg = {shreg[6:0], 1'b0};
          sda_lvl = shreg[7];
          dly_cnt = nonzero(cfg_delay); eng_phase = PH_WR_D;
        end
      end
      PH_RD_L: if (delay_over()) begin
        scl_lvl = 1'b1; shreg = {shreg[6:0], t.sda_in};
        dly_cnt = nonzero(cfg_short); eng_phase = PH_RD_H;
      end
      PH_RD_H: if (delay_over()) begin
        scl_lvl = 1'b0;
        if (bit_idx >= 4'd7) begin
          rx_last = shreg; sda_lvl = ~ack_lvl;
          dly_cnt = nonzero(cfg_delay); eng_phase = PH_AK_L;
        end else begin
          bit_idx++; dly_cnt = nonzero(cfg_delay); eng_phase = PH_RD_L;
        end
      end
      PH_AK_L: if (delay_over()) begin
        scl_lvl = 1'b1; dly_cnt = nonzero(cfg_delay); eng_phase = PH_AK_H;
      end
      PH_AK_H: if (delay_over()) begin
        scl_lvl = 1'b0; eng_phase = PH_IDLE; done = 1'b1;
      end
      default: eng_phase = PH_IDLE;
    endcase
    r.scl_release = scl_lvl;
    r.sda_release = sda_lvl;
    r.busy_res    = (eng_phase != PH_IDLE);
    r.done_res    = done;
    r.rx_byte     = rx_last;
    r.ack_error   = err_lvl;
  endtask

  task automatic check_field(input string label, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.cmd_valid <= 1'b0;
      cmd_if.func      <= '0;
      cmd_if.tx_byte   <= '0;
      cmd_if.ack_flag  <= 1'b0;
      cmd_if.sda_in    <= 1'b1;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        engine_step(offered, predicted);
        expected_lines_q.push_back(predicted);
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (bus_ticks_q.size() != 0) begin
          offered = bus_ticks_q.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.cmd_valid <= offered.cmd_valid;
          cmd_if.func      <= offered.func;
          cmd_if.tx_byte   <= offered.tx_byte;
          cmd_if.ack_flag  <= offered.ack_flag;
          cmd_if.sda_in    <= offered.sda_in;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 200);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls on a pattern that changes now and then.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_pat = '1;
      stall_pos = '0;
      stall_age = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_lines_q.size() == 0) begin
          $display("%0t ns: result with no expectation waiting, actual %0h", $time,
                   {res_if.scl_release, res_if.sda_release, res_if.busy_res,
                    res_if.done_res, res_if.rx_byte, res_if.ack_error});
          mismatches++;
        end else begin
          want = expected_lines_q.pop_front();
          check_field("scl_release", 8'(want.scl_release), 8'(res_if.scl_release));
          check_field("sda_release", 8'(want.sda_release), 8'(res_if.sda_release));
          check_field("busy_res", 8'(want.busy_res), 8'(res_if.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(res_if.done_res));
          check_field("rx_byte", want.rx_byte, res_if.rx_byte);
          check_field("ack_error", 8'(want.ack_error), 8'(res_if.ack_error));
        end
      end
      if (stall_age == 0) begin
        stall_age = 64;
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = 16'($urandom()) | 16'h0001;
          default: stall_pat = 16'($urandom() & $urandom()) | 16'h0001;
        endcase
      end
      stall_age--;
      res_if.ready <= stall_pat[stall_pos];
      stall_pos++;
    end
  end

  task automatic push_tick(input logic v, input logic [2:0] fn, input logic [7:0] data,
                           input logic ackf, input logic sda);
    cmd_t t;
    t.cmd_valid = v;
    t.func      = fn;
    t.tx_byte   = data;
    t.ack_flag  = ackf;
    t.sda_in    = sda;
    bus_ticks_q.push_back(t);
    ticks_pushed++;
  endtask

  // Offers one command, then the ticks it keeps the engine busy. The slave holds
  // SDA high for the given number of ack polls; noise offers commands while busy.
  task automatic issue(input logic [2:0] fn, input logic [7:0] data, input logic ackf,
                       input int unsigned high_polls, input bit noisy,
                       input int unsigned short_by);
    int unsigned dm;
    int unsigned sm;
    int unsigned dur;
    int unsigned k;
    logic        sda;
    dm = 32'(nonzero(cfg_delay));
    sm = 32'(nonzero(cfg_short));
    case (fn)
      FN_START, FN_STOP, FN_ACK_BIT: dur = 2 * dm;
      FN_WRITE:    dur = 24 * dm;
      FN_READ:     dur = 8 * (dm + sm) + 2 * dm;
      FN_WAIT_ACK: dur = (high_polls <= cfg_timeout) ? 2 * sm + high_polls + 1
                                                     : 2 * sm + cfg_timeout + 1 + 2 * dm;
      default:     dur = 0;
    endcase
    dur = (dur > short_by) ? dur - short_by : 0;
    push_tick(1'b1, fn, data, ackf, 1'($urandom_range(0, 1)));
    for (k = 1; k <= dur; k++) begin
      sda = 1'($urandom_range(0, 1));
      if (fn == FN_WAIT_ACK && k > 2 * sm && high_polls <= cfg_timeout)
        sda = (k <= 2 * sm + high_polls);
      else if (fn == FN_WAIT_ACK && k > 2 * sm && k <= 2 * sm + cfg_timeout + 1)
        sda = 1'b1;
      push_tick(noisy && $urandom_range(0, 9) == 0, 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
    end
    if (short_by == 0 && $urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 4))
        push_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    commands_issued++;
  endtask

  function automatic int unsigned pick_polls();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return cfg_timeout + $urandom_range(1, 3);
  endfunction

  // A well-formed bus sequence: start, address, ack, data bytes, an occasional ack bit, stop.
  task automatic bus_sequence();
    logic [7:0]  addr;
    int unsigned n;
    int unsigned i;
    bit          noisy;
    addr  = 8'($urandom_range(0, 255));
    n     = $urandom_range(1, 2);
    noisy = ($urandom_range(0, 3) == 0);
    issue(FN_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, noisy, 0);
    issue(FN_WRITE, addr, 1'($urandom_range(0, 1)), 0, noisy, 0);
    issue(FN_WAIT_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_polls(),
          noisy, 0);
    for (i = 0; i < n; i++) begin
      if (addr[0]) begin
        issue(FN_READ, 8'($urandom_range(0, 255)), (i != n - 1), 0, noisy, 0);
      end else begin
        issue(FN_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, noisy, 0);
        issue(FN_WAIT_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              pick_polls(), noisy, 0);
      end
    end
    if ($urandom_range(0, 5) == 0)
      issue(FN_ACK_BIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, noisy, 0);
    issue(FN_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, noisy, 0);
  endtask

  // Random commands, unused codes among them, sometimes cut short so that the next is dropped.
  task automatic noise_burst();
    repeat ($urandom_range(1, 3))
      issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            $urandom_range(0, cfg_timeout + 2), 1'b1,
            ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8));
  endtask

  // Waits until every result is in and the engine is idle.
  task automatic settle();
    forever begin
      while (bus_ticks_q.size() != 0 || expected_lines_q.size() != 0 || cmd_if.valid)
        @(negedge clk_i);
      if (eng_phase == PH_IDLE) break;
      repeat (32) push_tick(1'b0, FN_START, 8'h00, 1'b0, 1'($urandom_range(0, 1)));
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_DELAY:       cfg_delay   = value;
      CFG_SHORT_DELAY: cfg_short   = value;
      default:         cfg_timeout = value;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] d, input logic [7:0] s, input logic [7:0] t);
    write_reg(CFG_DELAY, d);
    write_reg(CFG_SHORT_DELAY, s);
    write_reg(CFG_ACK_TIMEOUT, t);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_DELAY;
    cfg_data_i       = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd_valid = 1'b0;
    cmd_if.func      = FN_START;
    cmd_if.tx_byte   = '0;
    cmd_if.ack_flag  = 1'b0;
    cmd_if.sda_in    = 1'b1;
    res_if.ready     = 1'b0;
    mismatches       = 0;
    commands_issued  = 0;
    ticks_pushed     = 0;
    engine_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned phase_base;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed part at the reset settings, unused codes included.
    issue(FN_START, 8'h00, 1'b0, 0, 1'b1, 0);
    issue(FN_WAIT_ACK, 8'h00, 1'b0, 1, 1'b0, 0);
    issue(FN_ACK_BIT, 8'h00, 1'b1, 0, 1'b0, 0);
    issue(3'd6, 8'h5A, 1'b1, 0, 1'b0, 0);
    issue(3'd7, 8'hA5, 1'b0, 0, 1'b0, 0);
    issue(FN_STOP, 8'h00, 1'b0, 0, 1'b0, 0);
    settle();

    // Zero in every register behaves as one tick; a zero timeout gives up at once.
    apply_settings(8'd0, 8'd0, 8'd0);
    issue(FN_START, 8'h00, 1'b0, 0, 1'b0, 0);
    issue(FN_WRITE, 8'hA5, 1'b0, 0, 1'b1, 0);
    issue(FN_WAIT_ACK, 8'h00, 1'b0, 1, 1'b0, 0);
    issue(FN_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0, 0);
    issue(FN_READ, 8'h00, 1'b0, 0, 1'b0, 0);
    issue(FN_STOP, 8'h00, 1'b0, 0, 1'b0, 0);
    settle();

    // The largest ack timeout with short delays.
    apply_settings(8'd1, 8'd1, 8'd255);
    issue(FN_WAIT_ACK, 8'h00, 1'b0, 2, 1'b1, 0);
    issue(FN_ACK_BIT, 8'h00, 1'b0, 0, 1'b0, 0);
    settle();

    // Random part, one setting of the registers per phase.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       apply_settings(8'd1, 8'd1, 8'd1);
        1:       apply_settings(8'd2, 8'd1, 8'd3);
        2:       apply_settings(8'd1, 8'd3, 8'd0);
        3:       apply_settings(8'd2, 8'd2, 8'd6);
        default: apply_settings(8'($urandom_range(1, 2)), 8'($urandom_range(1, 3)),
                                8'($urandom_range(0, 8)));
      endcase
      phase_base = ticks_pushed;
      while (ticks_pushed - phase_base < 60) begin
        if ($urandom_range(0, 99) < 85) bus_sequence();
        else noise_burst();
        // Now and then the sender holds off until every result is in.
        if ($urandom_range(0, 29) == 0) settle();
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> i2c_master_bit_engine_top.f
design/i2cm_pkg.sv
design/i2cm_in_if.sv
design/i2cm_out_if.sv
design/i2cm_engine.sv
design/i2c_master_bit_engine_top.sv
tb/testbench.sv
